// File: design/hpm_pkg.sv
// Shared types and constants for the heightfield patch min/max block.
package hpm_pkg;

  localparam int DEF_MAX_WIDTH      = 4096;
  localparam int DEF_MAX_PATCH_COLS = 1024;
  localparam int OUT_DEPTH          = 4;

  localparam logic signed [15:0] ACC_MIN_INIT = 16'sd32767;
  localparam logic signed [15:0] ACC_MAX_INIT = -16'sd32767;

  localparam logic [12:0]        GRID_WIDTH_RST  = 13'd4096;
  localparam logic [15:0]        GRID_HEIGHT_RST = 16'd4096;
  localparam logic [3:0]         PATCH_LOG2_RST  = 4'd4;
  localparam logic signed [15:0] NO_DATA_RST     = -16'sd32768;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_PATCH_LOG2  = 2'd2,
    CFG_NO_DATA     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [15:0] mn;
    logic signed [15:0] mx;
  } acc_t;

  localparam acc_t ACC_INIT = '{mn: ACC_MIN_INIT, mx: ACC_MAX_INIT};

  // One classified sample on its way through the pipeline.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [1:0]         upd;       // update the even / odd column entry
    logic               border;    // row shared with the next patch row
    logic               bank;      // bank of the current patch row
    logic               emit;      // last sample of a patch
    logic               emit_par;  // parity of the finished column
    logic               emit_hit;  // finished column lies in storage
    logic               last;
    logic [13:0]        prow;
    logic [9:0]         pcol;
  } item_t;

  typedef struct packed {
    logic upd;
    logic emit;
  } ram_op_t;

  typedef struct packed {
    logic [13:0]        prow;
    logic [9:0]         pcol;
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    logic               last;
  } result_t;

endpackage

// File: design/heightfield_patch_minmax_core.sv
// Top level of the heightfield patch min/max reduction.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------------
//   samples  | sample_valid / sample_stall | height_sample
//   patches  | patch_valid / patch_stall   | patch_row, patch_col, patch_min, patch_max,
//            |                            | last_patch
//   config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One sample per cycle while sample_stall is low. A sample is classified into the first
// register, reads its column accumulators in the next cycle and is merged and written
// back in the one after; a finished patch is then pushed into the result queue. After
// reset a clearing pass over the (MAX_PATCH_COLS + 1) / 2 entries of each memory sets all
// accumulators, with sample_stall held high. A result queue of OUT_DEPTH entries
// absorbs patch_stall; sample_stall rises once queue plus pipeline could fill it.
module heightfield_patch_minmax_core
  import hpm_pkg::*;
#(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_PATCH_COLS = DEF_MAX_PATCH_COLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] height_sample,
  output logic               patch_valid,
  input  logic               patch_stall,
  output logic [13:0]        patch_row,
  output logic [9:0]         patch_col,
  output logic signed [15:0] patch_min,
  output logic signed [15:0] patch_max,
  output logic               last_patch,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int HALF = (MAX_PATCH_COLS + 1) / 2;
  localparam int AW   = $clog2(HALF);
  localparam int CNTW = $clog2(OUT_DEPTH + 1);
  localparam int OCCW = $clog2(OUT_DEPTH + 3);

  logic [12:0]        grid_width;
  logic [15:0]        grid_height;
  logic [3:0]         patch_log2;
  logic signed [15:0] no_data_value;

  logic               accept;
  logic               s1_valid, s2_valid;
  item_t              s1_item, s2_item;
  logic [1:0][AW-1:0] s1_addr;

  logic               clr_busy;
  logic [AW-1:0]      clr_addr;

  ram_op_t            ram_op  [4];
  acc_t               ram_res [4];
  acc_t               sel_acc;
  result_t            res_next, head;
  logic               push;
  logic [CNTW-1:0]    fifo_count;
  logic [OCCW-1:0]    occupancy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= GRID_WIDTH_RST;
      grid_height   <= GRID_HEIGHT_RST;
      patch_log2    <= PATCH_LOG2_RST;
      no_data_value <= NO_DATA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width    <= cfg_data[12:0];
        CFG_GRID_HEIGHT: grid_height   <= cfg_data;
        CFG_PATCH_LOG2:  patch_log2    <= cfg_data[3:0];
        CFG_NO_DATA:     no_data_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold samples while clearing or while in-flight transactions could fill the queue
  assign occupancy    = OCCW'(s1_valid) + OCCW'(s2_valid) + OCCW'(fifo_count);
  assign sample_stall = clr_busy || (occupancy >= OCCW'(OUT_DEPTH));
  assign accept       = sample_valid && !sample_stall;

  hpm_pos #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_PATCH_COLS (MAX_PATCH_COLS)
  ) u_pos (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (height_sample),
    .grid_width    (grid_width),
    .grid_height   (grid_height),
    .patch_log2    (patch_log2),
    .no_data_value (no_data_value),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item),
    .s1_addr       (s1_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else begin
      s2_valid <= s1_valid;
      if (clr_busy) begin
        if (clr_addr == AW'(HALF - 1)) begin
          clr_busy <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_item <= s1_item;
  end

  // four memories: physical bank times column parity
  for (genvar gi = 0; gi < 4; gi++) begin : g_ram
    localparam int PB = gi / 2;
    localparam int PQ = gi % 2;

    assign ram_op[gi].upd  = s2_valid && s2_item.upd[PQ] &&
                             ((s2_item.bank == 1'(PB)) || s2_item.border);
    assign ram_op[gi].emit = s2_valid && s2_item.emit && s2_item.emit_hit &&
                             (s2_item.emit_par == 1'(PQ)) && (s2_item.bank == 1'(PB));

    hpm_acc_ram #(
      .DEPTH (HALF)
    ) u_ram (
      .clk      (clk),
      .rst      (rst),
      .rd_addr  (s1_addr[PQ]),
      .op       (ram_op[gi]),
      .sample   (s2_item.sample),
      .clr_en   (clr_busy),
      .clr_addr (clr_addr),
      .res      (ram_res[gi])
    );
  end

  always_comb begin
    sel_acc = s2_item.emit_hit ? ram_res[{s2_item.bank, s2_item.emit_par}] : ACC_INIT;
    res_next.prow = s2_item.prow;
    res_next.pcol = s2_item.pcol;
    res_next.mn   = sel_acc.mn;
    res_next.mx   = sel_acc.mx;
    res_next.last = s2_item.last;
    push          = s2_valid && s2_item.emit;
  end

  hpm_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res_next),
    .valid     (patch_valid),
    .stall     (patch_stall),
    .head      (head),
    .count     (fifo_count)
  );

  assign patch_row  = head.prow;
  assign patch_col  = head.pcol;
  assign patch_min  = head.mn;
  assign patch_max  = head.mx;
  assign last_patch = head.last;

endmodule

// File: design/hpm_pos.sv
// Stream position tracking and per-sample classification into the first pipeline register.
module hpm_pos
  import hpm_pkg::*;
#(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_PATCH_COLS = DEF_MAX_PATCH_COLS,
  localparam int AW = $clog2((MAX_PATCH_COLS + 1) / 2)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic signed [15:0]    sample,
  input  logic [12:0]           grid_width,
  input  logic [15:0]           grid_height,
  input  logic [3:0]            patch_log2,
  input  logic signed [15:0]    no_data_value,
  output logic                  s1_valid,
  output item_t                 s1_item,
  output logic [1:0][AW-1:0]    s1_addr
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCMP = (CW + 1 > 13) ? CW + 1 : 13;

  logic [CW-1:0]     col_pos;
  logic [15:0]       row_pos;
  logic              bank_sel;

  logic [WCMP-1:0]   gw_ext;
  logic [CW:0]       w_eff;
  logic [CW-1:0]     wm1;
  logic [15:0]       hm1;
  logic [3:0]        lg;
  logic [CW-1:0]     x, x_mask, ca, cb;
  logic [15:0]       y, y_mask, ym1;
  logic              xb, yb, x_end, y_end, border, has_a, has_b;
  logic              a_ok, b_ok, keep, ua, ub, col_end, row_end;
  item_t             item_next;
  logic [1:0][AW-1:0] addr_next;

  always_comb begin
    gw_ext = WCMP'(grid_width);
    if (gw_ext < WCMP'(2)) begin
      w_eff = (CW + 1)'(2);
    end else if (gw_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW + 1)'(gw_ext);
    end
    wm1 = CW'(w_eff - 1'b1);
    hm1 = (grid_height < 16'd2) ? 16'd1 : grid_height - 16'd1;
    lg  = (patch_log2 < 4'd2) ? 4'd2 : ((patch_log2 > 4'd10) ? 4'd10 : patch_log2);

    x_mask = ~({CW{1'b1}} << lg);
    y_mask = ~(16'hFFFF << lg);

    // a position beyond a shrunken grid acts as the last column or row
    x = (col_pos > wm1) ? wm1 : col_pos;
    y = (row_pos > hm1) ? hm1 : row_pos;

    xb     = (x & x_mask) == '0;
    yb     = (y & y_mask) == '0;
    x_end  = x == wm1;
    y_end  = y == hm1;
    border = (y != '0) && yb && !y_end;

    // a boundary column belongs to the patch on its left and the one on its right
    has_a = !(x_end && xb);
    has_b = (x != '0) && xb;
    ca    = x >> lg;
    cb    = (x - CW'(x != '0)) >> lg;
    a_ok  = 32'(ca) < MAX_PATCH_COLS;
    b_ok  = 32'(cb) < MAX_PATCH_COLS;

    keep = sample != no_data_value;
    ua   = keep && has_a && a_ok;
    ub   = keep && has_b && b_ok;

    col_end = (x != '0) && (xb || x_end);
    row_end = (y != '0) && (yb || y_end);
    ym1     = y - 16'd1;

    item_next.sample   = sample;
    item_next.upd[0]   = (ua && !ca[0]) || (ub && !cb[0]);
    item_next.upd[1]   = (ua && ca[0]) || (ub && cb[0]);
    item_next.border   = border;
    item_next.bank     = bank_sel;
    item_next.emit     = col_end && row_end;
    item_next.emit_par = cb[0];
    item_next.emit_hit = b_ok;
    item_next.last     = x_end && y_end;
    item_next.prow     = 14'(ym1 >> lg);
    item_next.pcol     = 10'(cb);

    // the two columns touched by one sample always differ in parity
    addr_next[0] = ca[0] ? AW'(cb >> 1) : AW'(ca >> 1);
    addr_next[1] = ca[0] ? AW'(ca >> 1) : AW'(cb >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      bank_sel <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (x_end) begin
          col_pos <= '0;
          if (y_end) begin
            row_pos  <= '0;
            bank_sel <= 1'b0;
          end else begin
            row_pos <= y + 16'd1;
            if (border) begin
              bank_sel <= ~bank_sel;
            end
          end
        end else begin
          col_pos <= x + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_next;
      s1_addr <= addr_next;
    end
  end

endmodule

// File: design/hpm_acc_ram.sv
// Column accumulator memory with registered read, write-back forwarding and min/max merge.
module hpm_acc_ram
  import hpm_pkg::*;
#(
  parameter int DEPTH = (DEF_MAX_PATCH_COLS + 1) / 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [AW-1:0]      rd_addr,
  input  ram_op_t            op,
  input  logic signed [15:0] sample,
  input  logic               clr_en,
  input  logic [AW-1:0]      clr_addr,
  output acc_t               res
);

  acc_t          mem [DEPTH];
  acc_t          rd_q, fwd_d, old, merged, wd;
  logic [AW-1:0] addr_q, fwd_addr;
  logic          fwd_v, we;

  always_comb begin
    // the read taken at the edge of the previous write-back misses it
    old    = (fwd_v && (fwd_addr == addr_q)) ? fwd_d : rd_q;
    merged = old;
    if (op.upd) begin
      if (sample < old.mn) begin
        merged.mn = sample;
      end
      if (sample > old.mx) begin
        merged.mx = sample;
      end
    end
    we  = op.upd || op.emit;
    wd  = op.emit ? ACC_INIT : merged;
    res = merged;
  end

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_addr] <= ACC_INIT;
    end else if (we) begin
      mem[addr_q] <= wd;
    end
    rd_q     <= mem[rd_addr];
    addr_q   <= rd_addr;
    fwd_addr <= addr_q;
    fwd_d    <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_v <= 1'b0;
    end else begin
      fwd_v <= we && !clr_en;
    end
  end

endmodule

// File: design/hpm_out_fifo.sv
// Result queue between the pipeline and the output channel.
module hpm_out_fifo
  import hpm_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH,
  localparam int PW   = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  result_t         push_data,
  output logic            valid,
  input  logic            stall,
  output result_t         head,
  output logic [CNTW-1:0] count
);

  result_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic          pop;

  assign valid = count != '0;
  assign pop   = valid && !stall;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
